### rtl/crc_pkg.sv
package crc_pkg;

  localparam int MAX_SIDE  = 512;
  localparam int FRAC_BITS = 8;

  localparam int CFG_W     = 10;
  localparam int CHAR_W    = 8;
  localparam int COORD_W   = 20;
  localparam int R_W       = 20;
  localparam int PIX_W     = 9;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam int SIDE_W  = $clog2(MAX_SIDE);
  localparam int CNT_W   = $clog2(MAX_SIDE + 1);
  localparam int CMP_W   = ((CNT_W > PIX_W) ? CNT_W : PIX_W) + 1;
  localparam int ADDR_W  = 2 * SIDE_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int POS_W  = SIDE_W + FRAC_BITS;
  localparam int DIFF_W = ((POS_W > COORD_W) ? POS_W : COORD_W) + 2;
  localparam int ABS_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int RSQ_W  = 2 * R_W;
  localparam int ONE    = 1 << FRAC_BITS;

  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h63;
  localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h43;

  localparam logic [CFG_W-1:0]  WIDTH_RESET  = 10'd1;
  localparam logic [CFG_W-1:0]  HEIGHT_RESET = 10'd1;
  localparam logic [CHAR_W-1:0] BG_RESET     = 8'd32;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_RADIUS = 3'd1,
    ST_BAD_SHAPE  = 3'd2,
    ST_BLOCKED    = 3'd3,
    ST_OUTSIDE    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BG     = 2'd2
  } cfg_e;

  typedef struct packed {
    logic    load;
    logic    setup;
    logic    scan_clr;
    logic    scan_adv;
    logic    clear_mode;
    logic    rd_en;
    logic    res_load;
    status_e res_status;
    logic    res_use_rdata;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic r_zero;
    logic shape_ok;
    logic rd_outside;
    logic scan_last;
    logic pipe_busy;
  } stat_t;

endpackage

### rtl/crc_ram.sv
module crc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/crc_dpath.sv
module crc_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [crc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [crc_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic [1:0]                           operation_i,
  input  logic [crc_pkg::CHAR_W-1:0]           shape_code_i,
  input  logic signed [crc_pkg::COORD_W-1:0]   center_x_i,
  input  logic signed [crc_pkg::COORD_W-1:0]   center_y_i,
  input  logic [crc_pkg::R_W-1:0]              radius_i,
  input  logic [crc_pkg::CHAR_W-1:0]           fill_char_i,
  input  logic [crc_pkg::PIX_W-1:0]            pixel_col_i,
  input  logic [crc_pkg::PIX_W-1:0]            pixel_row_i,
  input  crc_pkg::cmd_t                        cmd_i,
  output crc_pkg::stat_t                       stat_o,
  output logic [crc_pkg::STATUS_W-1:0]         status_o,
  output logic [crc_pkg::CHAR_W-1:0]           pixel_char_o
);

  localparam int SIDE_W = crc_pkg::SIDE_W;
  localparam int CNT_W  = crc_pkg::CNT_W;
  localparam int CMP_W  = crc_pkg::CMP_W;
  localparam int ADDR_W = crc_pkg::ADDR_W;
  localparam int DIFF_W = crc_pkg::DIFF_W;
  localparam int ABS_W  = crc_pkg::ABS_W;
  localparam int SQ_W   = crc_pkg::SQ_W;
  localparam int D2_W   = crc_pkg::D2_W;
  localparam int RSQ_W  = crc_pkg::RSQ_W;
  localparam int R_W    = crc_pkg::R_W;
  localparam int CHAR_W = crc_pkg::CHAR_W;

  function automatic logic [CNT_W-1:0] eff_side(input logic [crc_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end
    if (int'(v) > crc_pkg::MAX_SIDE) begin
      return CNT_W'(crc_pkg::MAX_SIDE);
    end
    return CNT_W'(v);
  endfunction

  logic [crc_pkg::CFG_W-1:0] wd_q, ht_q;
  logic [CHAR_W-1:0]         bg_q;
  logic [CNT_W-1:0]          w, h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q <= crc_pkg::WIDTH_RESET;
      ht_q <= crc_pkg::HEIGHT_RESET;
      bg_q <= crc_pkg::BG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crc_pkg::CFG_WIDTH:  wd_q <= cfg_data_i;
        crc_pkg::CFG_HEIGHT: ht_q <= cfg_data_i;
        crc_pkg::CFG_BG:     bg_q <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign w = eff_side(wd_q);
  assign h = eff_side(ht_q);

  crc_pkg::op_e                  op_q;
  logic [CHAR_W-1:0]             shape_q, fill_q;
  logic signed [crc_pkg::COORD_W-1:0] cx_q, cy_q;
  logic [R_W-1:0]                r_q;
  logic [crc_pkg::PIX_W-1:0]     pcol_q, prow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= crc_pkg::op_e'(operation_i);
      shape_q <= shape_code_i;
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      r_q     <= radius_i;
      fill_q  <= fill_char_i;
      pcol_q  <= pixel_col_i;
      prow_q  <= pixel_row_i;
    end
  end

  logic [RSQ_W-1:0] outer_q, inner_q;
  logic             has_inner_q, filled_q;
  logic [R_W-1:0]   rm1;

  assign rm1 = r_q - R_W'(crc_pkg::ONE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      outer_q     <= RSQ_W'(r_q) * RSQ_W'(r_q);
      inner_q     <= RSQ_W'(rm1) * RSQ_W'(rm1);
      has_inner_q <= r_q >= R_W'(crc_pkg::ONE);
      filled_q    <= shape_q == crc_pkg::SHAPE_FILLED;
    end
  end

  logic [SIDE_W-1:0] col_q, row_q;
  logic              mode_q;
  logic              col_last, row_last;

  assign col_last = CNT_W'(col_q) == w - CNT_W'(1);
  assign row_last = CNT_W'(row_q) == h - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      col_q  <= '0;
      row_q  <= '0;
      mode_q <= cmd_i.clear_mode;
    end else if (cmd_i.scan_adv) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + SIDE_W'(1);
      end else begin
        col_q <= col_q + SIDE_W'(1);
      end
    end
  end

  logic [DIFF_W-1:0] posx, posy, dx, dy;

  assign posx = DIFF_W'(col_q) << crc_pkg::FRAC_BITS;
  assign posy = DIFF_W'(row_q) << crc_pkg::FRAC_BITS;
  assign dx   = posx - DIFF_W'(cx_q);
  assign dy   = posy - DIFF_W'(cy_q);

  logic              v1_q, v2_q, v3_q, v4_q;
  logic [ADDR_W-1:0] a1_q, a2_q, a3_q, a4_q;
  logic [DIFF_W-1:0] dx1_q, dy1_q;
  logic [ABS_W-1:0]  ax2_q, ay2_q;
  logic [SQ_W-1:0]   sx3_q, sy3_q;
  logic [D2_W-1:0]   d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_adv;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= {row_q, col_q};
    dx1_q <= dx;
    dy1_q <= dy;
    a2_q  <= a1_q;
    ax2_q <= dx1_q[DIFF_W-1] ? ABS_W'(-dx1_q) : ABS_W'(dx1_q);
    ay2_q <= dy1_q[DIFF_W-1] ? ABS_W'(-dy1_q) : ABS_W'(dy1_q);
    a3_q  <= a2_q;
    sx3_q <= SQ_W'(ax2_q) * SQ_W'(ax2_q);
    sy3_q <= SQ_W'(ay2_q) * SQ_W'(ay2_q);
    a4_q  <= a3_q;
    d2_q  <= D2_W'(sx3_q) + D2_W'(sy3_q);
  end

  logic              hit, we;
  logic [CHAR_W-1:0] wdata;
  logic [CHAR_W-1:0] rdata;

  assign hit = mode_q || ((d2_q <= D2_W'(outer_q)) &&
               (filled_q || !has_inner_q || (d2_q > D2_W'(inner_q))));
  assign we    = v4_q && hit;
  assign wdata = mode_q ? bg_q : fill_q;

  crc_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(crc_pkg::RAM_DEPTH)
  ) u_canvas (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(a4_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i({SIDE_W'(prow_q), SIDE_W'(pcol_q)}),
    .rdata_o(rdata)
  );

  logic [crc_pkg::STATUS_W-1:0] status_q;
  logic [CHAR_W-1:0]            pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      pix_q    <= cmd_i.res_use_rdata ? rdata : '0;
    end
  end

  assign status_o     = status_q;
  assign pixel_char_o = pix_q;

  assign stat_o.op         = op_q;
  assign stat_o.r_zero     = r_q == '0;
  assign stat_o.shape_ok   = (shape_q == crc_pkg::SHAPE_OUTLINE) ||
                             (shape_q == crc_pkg::SHAPE_FILLED);
  assign stat_o.rd_outside = (CMP_W'(pcol_q) >= CMP_W'(w)) ||
                             (CMP_W'(prow_q) >= CMP_W'(h));
  assign stat_o.scan_last  = col_last && row_last;
  assign stat_o.pipe_busy  = v1_q || v2_q || v3_q || v4_q;

endmodule

### rtl/crc_ctrl.sv
module crc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  input  crc_pkg::stat_t stat_i,
  output crc_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SETUP,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic             err_q, err_d;
  crc_pkg::status_e code_q, code_d;
  logic             use_rd_q, use_rd_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    code_d      = code_q;
    use_rd_d    = use_rd_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o               = '0;
    cmd_o.res_status    = code_q;
    cmd_o.res_use_rdata = use_rd_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        code_d   = crc_pkg::ST_OK;
        use_rd_d = 1'b0;
        state_d  = S_RESP;
        case (stat_i.op)
          crc_pkg::OP_DRAW: begin
            if (err_q) begin
              code_d = crc_pkg::ST_BLOCKED;
            end else if (stat_i.r_zero) begin
              code_d = crc_pkg::ST_BAD_RADIUS;
              err_d  = 1'b1;
            end else if (!stat_i.shape_ok) begin
              code_d = crc_pkg::ST_BAD_SHAPE;
              err_d  = 1'b1;
            end else begin
              state_d = S_SETUP;
            end
          end
          crc_pkg::OP_READ: begin
            if (stat_i.rd_outside) begin
              code_d = crc_pkg::ST_OUTSIDE;
            end else begin
              cmd_o.rd_en = 1'b1;
              use_rd_d    = 1'b1;
            end
          end
          crc_pkg::OP_CLEAR: begin
            err_d            = 1'b0;
            cmd_o.scan_clr   = 1'b1;
            cmd_o.clear_mode = 1'b1;
            state_d          = S_SCAN;
          end
          default: ;
        endcase
      end
      S_SETUP: begin
        cmd_o.setup    = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_adv = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= 1'b0;
      code_q      <= crc_pkg::ST_OK;
      use_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      code_q      <= code_d;
      use_rd_q    <= use_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

### rtl/circle_rasterizer_canvas_unit.sv
// Read, bad-command and blocked-draw items pass the decode and response states; draw
// adds setup, scan and drain, clear adds scan and drain. Scan visits one pixel
// per cycle; hits use the single RAM write port, behind a 4-stage distance pipe.
// One item in flight; the next input is taken while a result waits for transfer.
// Reset clears control, error latch and configuration (width 1, height 1, blank 32);
// the canvas RAM is not cleared and holds nothing defined until a clear or draw.
module circle_rasterizer_canvas_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [crc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [crc_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           operation_i,
  input  logic [crc_pkg::CHAR_W-1:0]           shape_code_i,
  input  logic signed [crc_pkg::COORD_W-1:0]   center_x_i,
  input  logic signed [crc_pkg::COORD_W-1:0]   center_y_i,
  input  logic [crc_pkg::R_W-1:0]              radius_i,
  input  logic [crc_pkg::CHAR_W-1:0]           fill_char_i,
  input  logic [crc_pkg::PIX_W-1:0]            pixel_col_i,
  input  logic [crc_pkg::PIX_W-1:0]            pixel_row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [crc_pkg::STATUS_W-1:0]         status_o,
  output logic [crc_pkg::CHAR_W-1:0]           pixel_char_o
);

  crc_pkg::cmd_t  cmd;
  crc_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  crc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .operation_i (operation_i),
    .shape_code_i(shape_code_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .fill_char_i (fill_char_i),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (status_o),
    .pixel_char_o(pixel_char_o)
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= crc_pkg::ST_OUTSIDE))
    else $error("status code out of range");

  a_pixel_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != crc_pkg::ST_OK)) |-> (pixel_char_o == '0))
    else $error("pixel data with failing status");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second input taken while busy");

endmodule
